// File: design/aldb_pkg.sv
package aldb_pkg;

  localparam int unsigned AdcW      = 12;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned DebW      = 16;
  localparam int unsigned BtnIdxW   = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 57;
  localparam int unsigned SetupRegs = 4;

  // button setup word layout
  localparam int unsigned BandLoLsb = 0;
  localparam int unsigned BandHiLsb = 12;
  localparam int unsigned KeyLsb    = 24;
  localparam int unsigned InUseBit  = 56;

  localparam logic [DebW-1:0] DebounceRst = DebW'(50);

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounce = 3'd0,
    CfgButton0  = 3'd1,
    CfgButton1  = 3'd2,
    CfgButton2  = 3'd3,
    CfgButton3  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    FuncSample = 1'b0,
    FuncRead   = 1'b1
  } func_e;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic               func;
    logic [BtnIdxW-1:0] button_sel;
    logic [AdcW-1:0]    sample_value;
    logic [TimeW-1:0]   time_ms;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            pressed;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } push_req_t;

endpackage

// File: design/aldb_in_if.sv
interface aldb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [aldb_pkg::BtnIdxW-1:0] button_sel;
  logic [aldb_pkg::AdcW-1:0]    sample_value;
  logic [aldb_pkg::TimeW-1:0]   time_ms;

  modport source (output valid, func, button_sel, sample_value, time_ms, input ready);
  modport sink   (input valid, func, button_sel, sample_value, time_ms, output ready);
endinterface

// File: design/aldb_out_if.sv
interface aldb_out_if;
  logic                      valid;
  logic                      ready;
  logic [aldb_pkg::KeyW-1:0] key_code;
  logic                      pressed;
  logic                      more_pending;

  modport source (output valid, key_code, pressed, more_pending, input ready);
  modport sink   (input valid, key_code, pressed, more_pending, output ready);
endinterface

// File: design/aldb_ram.sv
module aldb_ram #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/aldb_btn.sv
module aldb_btn #(
  parameter int unsigned BUTTONS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  aldb_pkg::cfg_wr_t            cfg_i,
  input  logic                         fire_i,
  input  logic [aldb_pkg::BtnIdxW-1:0] idx_i,
  input  logic [aldb_pkg::AdcW-1:0]    value_i,
  input  logic [aldb_pkg::TimeW-1:0]   time_i,
  output aldb_pkg::push_req_t          push_o
);

  logic [aldb_pkg::DebW-1:0]     debounce_q;
  logic [aldb_pkg::CfgDataW-1:0] setup_q   [BUTTONS];
  logic                          pressed_q [BUTTONS];
  logic [aldb_pkg::TimeW-1:0]    last_q    [BUTTONS];

  logic [aldb_pkg::CfgDataW-1:0] sel_setup;
  logic                          sel_pressed;
  logic [aldb_pkg::TimeW-1:0]    sel_last;
  logic                          hit;
  logic [aldb_pkg::AdcW-1:0]     band_lo, band_hi;
  logic                          level;
  logic [aldb_pkg::TimeW-1:0]    elapsed;
  logic                          settled;
  logic                          change;

  // one-hot pick of the addressed button
  always_comb begin
    sel_setup   = '0;
    sel_pressed = 1'b0;
    sel_last    = '0;
    hit         = 1'b0;
    for (int b = 0; b < BUTTONS; b++) begin
      if (int'(idx_i) == b) begin
        sel_setup   = sel_setup | setup_q[b];
        sel_pressed = sel_pressed | pressed_q[b];
        sel_last    = sel_last | last_q[b];
        hit         = 1'b1;
      end
    end
  end

  assign band_lo = sel_setup[aldb_pkg::BandLoLsb +: aldb_pkg::AdcW];
  assign band_hi = sel_setup[aldb_pkg::BandHiLsb +: aldb_pkg::AdcW];
  assign level   = (value_i > band_lo) && (value_i <= band_hi);
  assign elapsed = time_i - sel_last;
  assign settled = elapsed >= aldb_pkg::TimeW'(debounce_q);
  assign change  = fire_i && hit && sel_setup[aldb_pkg::InUseBit] && settled &&
                   (level != sel_pressed);

  assign push_o.valid      = change;
  assign push_o.ev.key     = sel_setup[aldb_pkg::KeyLsb +: aldb_pkg::KeyW];
  assign push_o.ev.pressed = level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= aldb_pkg::DebounceRst;
      for (int b = 0; b < BUTTONS; b++) begin
        setup_q[b]   <= '0;
        pressed_q[b] <= 1'b0;
        last_q[b]    <= '0;
      end
    end else begin
      if (cfg_i.we && cfg_i.idx == aldb_pkg::CfgDebounce) begin
        debounce_q <= cfg_i.data[aldb_pkg::DebW-1:0];
      end
      for (int b = 0; b < BUTTONS; b++) begin
        // only the first SetupRegs buttons have a writable setup register
        if (b < aldb_pkg::SetupRegs && cfg_i.we &&
            cfg_i.idx == aldb_pkg::CfgIdxW'(b + 1)) begin
          setup_q[b] <= cfg_i.data;
        end
        if (change && int'(idx_i) == b) begin
          pressed_q[b] <= level;
          last_q[b]    <= time_i;
        end
      end
    end
  end

endmodule

// File: design/aldb_queue.sv
module aldb_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aldb_pkg::push_req_t push_i,
  input  logic                pop_i,
  output logic                pop_ready_o,
  aldb_out_if.source          out_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = PtrW + 1;
  localparam int unsigned EvW  = $bits(aldb_pkg::event_t);

  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, empty_q, more_q;

  logic            full, empty, do_push, do_pop;
  logic [SumW-1:0] tail_sum;
  logic [PtrW-1:0] tail;
  logic [EvW-1:0]  rdata;
  aldb_pkg::event_t rd_ev;

  assign full     = count_q == CntW'(QUEUE_DEPTH);
  assign empty    = count_q == '0;
  assign do_push  = push_i.valid && !full;
  assign do_pop   = pop_i && !empty;
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail     = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
                    PtrW'(tail_sum - SumW'(QUEUE_DEPTH)) : PtrW'(tail_sum);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop) begin
      head_d  = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
      count_d = count_q - CntW'(1);
    end
  end

  aldb_ram #(
    .Width (EvW),
    .Depth (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (tail),
    .wdata_i (push_i.ev),
    .re_i    (do_pop),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      empty_q     <= 1'b0;
      more_q      <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (pop_i) begin
        out_valid_q <= 1'b1;
        empty_q     <= empty;
        more_q      <= count_q > CntW'(1);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // an empty read shows key 0, released
  assign rd_ev              = aldb_pkg::event_t'(rdata);
  assign out_o.valid        = out_valid_q;
  assign out_o.key_code     = empty_q ? '0 : rd_ev.key;
  assign out_o.pressed      = !empty_q && rd_ev.pressed;
  assign out_o.more_pending = more_q;
  assign pop_ready_o        = !out_valid_q || out_o.ready;

endmodule

// File: design/adc_ladder_button_debouncer.sv
// Resistor-ladder keypad decoder. Sample items (func 0) carry one button's
// ADC reading and a ms timestamp; the button reads pressed when
// band low < sample <= band high, and a change is taken only if the button
// is in use and at least debounce_time ms (32-bit wrapping) have passed
// since its last taken change. Each taken change queues a (key, pressed)
// event in a QUEUE_DEPTH-entry FIFO; a push into a full FIFO is dropped.
// Read items (func 1) pop the oldest event and give one result item with
// more_pending set if events remain; an empty FIFO gives key 0, released.
// Sample items give no result. Rate: one item per cycle unless a read waits.
// Every item is registered in the input register, where debounce and queue
// bookkeeping are done; a read's result lands in the output register
// (FIFO RAM read data) in the cycle after it leaves the input register.
// A read waits there only while the previous result has not been taken.
// Config registers (write only while idle): 0 debounce_time, 1..4 setup of
// buttons 0..3 (bits 11:0 band low, 23:12 band high, 55:24 key, 56 in use).
module adc_ladder_button_debouncer #(
  parameter int unsigned BUTTONS     = 4,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aldb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [aldb_pkg::CfgDataW-1:0] cfg_wdata_i,
  aldb_in_if.sink                       in_i,
  aldb_out_if.source                    out_o
);

  aldb_pkg::cfg_wr_t   cfg;
  aldb_pkg::in_item_t  s1_q;
  logic                s1_valid_q;
  logic                s1_adv;
  logic                s1_is_read;
  logic                pop_ready;
  aldb_pkg::push_req_t push;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  // input register: samples always move on, reads need the output slot
  assign s1_is_read = s1_q.func == aldb_pkg::FuncRead;
  assign s1_adv     = s1_valid_q && (!s1_is_read || pop_ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q.func         <= in_i.func;
      s1_q.button_sel   <= in_i.button_sel;
      s1_q.sample_value <= in_i.sample_value;
      s1_q.time_ms      <= in_i.time_ms;
    end
  end

  aldb_btn #(
    .BUTTONS (BUTTONS)
  ) u_btn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .fire_i  (s1_adv && !s1_is_read),
    .idx_i   (s1_q.button_sel),
    .value_i (s1_q.sample_value),
    .time_i  (s1_q.time_ms),
    .push_o  (push)
  );

  aldb_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (s1_adv && s1_is_read),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

// File: design/aldb_chk.sv
module aldb_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_func_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [aldb_pkg::KeyW-1:0] out_key_i,
  input logic                      out_pressed_i,
  input logic                      out_more_i
);

  // reads accepted whose result has not yet been taken
  logic [2:0] open_q;
  logic       rd_acc, res_acc;

  assign rd_acc  = in_valid_i && in_ready_i && in_func_i == aldb_pkg::FuncRead;
  assign res_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 3'(rd_acc) - 3'(res_acc);
    end
  end

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 3'd2)
    else $error("more than two reads in flight");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != 3'd0)
    else $error("result without a read");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == 3'd0 |-> in_ready_i)
    else $error("input stalled with no read pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_key_i) &&
      $stable(out_pressed_i) && $stable(out_more_i))
    else $error("stalled result changed");

endmodule

bind adc_ladder_button_debouncer aldb_chk u_aldb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_func_i     (in_i.func),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_key_i     (out_o.key_code),
  .out_pressed_i (out_o.pressed),
  .out_more_i    (out_o.more_pending)
);
